FILE: rtl/swia_pkg.sv
// Shared types, codes and limits of the square-wave injection accumulator.
package swia_pkg;

    localparam int unsigned CAPTURE_MAX     = 1024;
    localparam int unsigned HALF_CYCLES_MAX = 4096;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_PERIOD   = 3'd0,
        REG_CAPTURE_START = 3'd1,
        REG_CAPTURE_LEN   = 3'd2,
        REG_HALF_TOTAL    = 3'd3,
        REG_FAULT_LIMIT   = 3'd4,
        REG_CURRENT_LIMIT = 3'd5,
        REG_SPEED_LIMIT   = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_RUNNING   = 3'd1,
        ST_DONE      = 3'd2,
        ST_FAULT     = 3'd3,
        ST_OVERSPEED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        DRV_NONE     = 3'd0,
        DRV_POSITIVE = 3'd1,
        DRV_NEGATIVE = 3'd2,
        DRV_ZERO     = 3'd3,
        DRV_ABORT    = 3'd4
    } drive_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] capture_start;
        logic [10:0] capture_len;
        logic [12:0] half_total;
        logic [15:0] fault_limit;
        logic [14:0] current_limit;
        logic [14:0] speed_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         command;
        logic               motor_fault;
        logic               angle_valid;
        logic               bus_valid;
        logic [15:0]        bus_millivolt;
        logic               pwm_saturated;
        logic signed [15:0] current_d;
        logic signed [15:0] current_q;
        logic signed [15:0] speed;
    } sample_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         drive_command;
        logic [11:0]        positive_half_count;
        logic [11:0]        negative_half_count;
        logic [37:0]        positive_voltage_sum;
        logic [37:0]        negative_voltage_sum;
        logic signed [27:0] positive_delta_sum;
        logic signed [27:0] negative_delta_sum;
        logic signed [39:0] positive_current_sum;
        logic signed [39:0] negative_current_sum;
    } result_t;

endpackage

FILE: rtl/swia_cfg.sv
// Configuration register file, lengths stored already saturated.
module swia_cfg
    import swia_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    localparam logic [10:0] CAP_SAT  = 11'(CAPTURE_MAX);
    localparam logic [12:0] HALF_SAT = 13'(HALF_CYCLES_MAX);

    cfg_t cfg_reg;
    logic [10:0] cap_len_w;
    logic [12:0] half_tot_w;

    assign cap_len_w  = (cfg_wdata[10:0] > CAP_SAT) ? CAP_SAT : cfg_wdata[10:0];
    assign half_tot_w = (cfg_wdata[12:0] > HALF_SAT) ? HALF_SAT : cfg_wdata[12:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period   <= 16'd2;
            cfg_reg.capture_start <= 16'd0;
            cfg_reg.capture_len   <= 11'd2;
            cfg_reg.half_total    <= 13'd4;
            cfg_reg.fault_limit   <= 16'd1;
            cfg_reg.current_limit <= 15'h7FFF;
            cfg_reg.speed_limit   <= 15'h7FFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HALF_PERIOD:   cfg_reg.half_period   <= cfg_wdata;
                REG_CAPTURE_START: cfg_reg.capture_start <= cfg_wdata;
                REG_CAPTURE_LEN:   cfg_reg.capture_len   <= cap_len_w;
                REG_HALF_TOTAL:    cfg_reg.half_total    <= half_tot_w;
                REG_FAULT_LIMIT:   cfg_reg.fault_limit   <= cfg_wdata;
                REG_CURRENT_LIMIT: cfg_reg.current_limit <= cfg_wdata[14:0];
                REG_SPEED_LIMIT:   cfg_reg.speed_limit   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/swia_in_stage.sv
// Input register stage holding one accepted sample item.
module swia_in_stage
    import swia_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_item,
    input  logic    take,
    output logic    item_valid,
    output sample_t item
);

    logic    valid_reg;
    sample_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: rtl/swia_engine.sv
// Sequencer state, window capture, polarity totals and result register.
module swia_engine
    import swia_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  sample_t item,
    output logic    take,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t result
);

    logic               armed_reg, armed_next;
    logic               done_reg, done_next;
    logic [15:0]        phase_reg, phase_next;
    logic [12:0]        half_reg, half_next;
    logic [10:0]        cnt_reg, cnt_next;
    logic [15:0]        ovs_reg, ovs_next;
    logic signed [15:0] first_reg, first_next;
    logic signed [15:0] last_reg, last_next;
    logic signed [26:0] win_i_reg, win_i_next;
    logic [25:0]        win_v_reg, win_v_next;
    logic [11:0]        pcnt_reg, pcnt_next, ncnt_reg, ncnt_next;
    logic [37:0]        pv_reg, pv_next, nv_reg, nv_next;
    logic signed [27:0] pd_reg, pd_next, nd_reg, nd_next;
    logic signed [39:0] pc_reg, pc_next, nc_reg, nc_next;

    logic               m_valid_reg;
    result_t            result_reg;
    status_t            status;
    drive_t             drive;

    logic signed [16:0] cd_x, cq_x, spd_x, ilim, slim;
    logic               safety_bad, overspeed;
    logic [15:0]        phase_off;
    logic               cap_hit, half_end, last_half;
    logic [10:0]        cnt_cap;
    logic signed [15:0] first_cap, last_cap;
    logic signed [26:0] win_i_cap;
    logic [25:0]        win_v_cap;
    logic signed [16:0] delta;
    logic [12:0]        half_inc;
    logic [15:0]        ovs_inc;

    assign take = item_valid && (!m_valid_reg || m_ready);

    assign cd_x  = 17'(item.current_d);
    assign cq_x  = 17'(item.current_q);
    assign spd_x = 17'(item.speed);
    assign ilim  = $signed({2'b00, cfg.current_limit});
    assign slim  = $signed({2'b00, cfg.speed_limit});

    assign safety_bad = item.motor_fault || !item.angle_valid || !item.bus_valid
                     || item.pwm_saturated
                     || (cd_x > ilim) || (cd_x < -ilim)
                     || (cq_x > ilim) || (cq_x < -ilim);
    assign overspeed  = (spd_x > slim) || (spd_x < -slim);

    assign phase_off = phase_reg - cfg.capture_start;
    assign cap_hit   = (phase_reg >= cfg.capture_start)
                    && (phase_off < {5'd0, cfg.capture_len});
    assign cnt_cap   = cap_hit ? cnt_reg + 11'd1 : cnt_reg;
    assign first_cap = (cap_hit && cnt_reg == 11'd0) ? item.current_d : first_reg;
    assign last_cap  = cap_hit ? item.current_d : last_reg;
    assign win_i_cap = cap_hit ? win_i_reg + 27'(item.current_d) : win_i_reg;
    assign win_v_cap = cap_hit ? win_v_reg + {10'd0, item.bus_millivolt} : win_v_reg;
    assign delta     = 17'(last_cap) - 17'(first_cap);
    assign half_end  = ({1'b0, phase_reg} + 17'd1) >= {1'b0, cfg.half_period};
    assign half_inc  = half_reg + 13'd1;
    assign last_half = half_inc >= cfg.half_total;
    assign ovs_inc   = (ovs_reg == 16'hFFFF) ? ovs_reg : ovs_reg + 16'd1;

    always_comb begin
        armed_next = armed_reg;
        done_next  = done_reg;
        phase_next = phase_reg;
        half_next  = half_reg;
        cnt_next   = cnt_reg;
        ovs_next   = ovs_reg;
        first_next = first_reg;
        last_next  = last_reg;
        win_i_next = win_i_reg;
        win_v_next = win_v_reg;
        pcnt_next  = pcnt_reg;
        ncnt_next  = ncnt_reg;
        pv_next    = pv_reg;
        nv_next    = nv_reg;
        pd_next    = pd_reg;
        nd_next    = nd_reg;
        pc_next    = pc_reg;
        nc_next    = nc_reg;
        status     = ST_IGNORED;
        drive      = DRV_NONE;
        case (item.command)
            CMD_START: begin
                armed_next = 1'b1;
                done_next  = 1'b0;
                phase_next = '0;
                half_next  = '0;
                cnt_next   = '0;
                ovs_next   = '0;
                first_next = '0;
                last_next  = '0;
                win_i_next = '0;
                win_v_next = '0;
                pcnt_next  = '0;
                ncnt_next  = '0;
                pv_next    = '0;
                nv_next    = '0;
                pd_next    = '0;
                nd_next    = '0;
                pc_next    = '0;
                nc_next    = '0;
                status     = ST_RUNNING;
            end
            CMD_STOP: begin
                armed_next = 1'b0;
                done_next  = 1'b0;
            end
            CMD_SAMPLE: begin
                if (armed_reg && !done_reg) begin
                    if (safety_bad) begin
                        armed_next = 1'b0;
                        done_next  = 1'b1;
                        status     = ST_FAULT;
                        drive      = DRV_ABORT;
                    end else if (overspeed) begin
                        ovs_next = ovs_inc;
                        if (ovs_inc >= cfg.fault_limit) begin
                            armed_next = 1'b0;
                            done_next  = 1'b1;
                            status     = ST_FAULT;
                            drive      = DRV_ABORT;
                        end else begin
                            status = ST_OVERSPEED;
                        end
                    end else begin
                        ovs_next   = '0;
                        status     = ST_RUNNING;
                        if (phase_reg == 16'd0) begin
                            drive = half_reg[0] ? DRV_NEGATIVE : DRV_POSITIVE;
                        end
                        cnt_next   = cnt_cap;
                        first_next = first_cap;
                        last_next  = last_cap;
                        win_i_next = win_i_cap;
                        win_v_next = win_v_cap;
                        if (!half_end) begin
                            phase_next = phase_reg + 16'd1;
                        end else if (cnt_cap != cfg.capture_len) begin
                            armed_next = 1'b0;
                            done_next  = 1'b1;
                            status     = ST_FAULT;
                            drive      = DRV_ABORT;
                        end else begin
                            if (half_reg[0]) begin
                                ncnt_next = ncnt_reg + 12'd1;
                                nv_next   = nv_reg + {12'd0, win_v_cap};
                                nd_next   = nd_reg + 28'(delta);
                                nc_next   = nc_reg + 40'(win_i_cap);
                            end else begin
                                pcnt_next = pcnt_reg + 12'd1;
                                pv_next   = pv_reg + {12'd0, win_v_cap};
                                pd_next   = pd_reg + 28'(delta);
                                pc_next   = pc_reg + 40'(win_i_cap);
                            end
                            half_next  = half_inc;
                            phase_next = '0;
                            cnt_next   = '0;
                            first_next = '0;
                            last_next  = '0;
                            win_i_next = '0;
                            win_v_next = '0;
                            if (last_half) begin
                                drive      = DRV_ZERO;
                                armed_next = 1'b0;
                                done_next  = 1'b1;
                                status     = ST_DONE;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg   <= 1'b0;
            done_reg    <= 1'b0;
            phase_reg   <= '0;
            half_reg    <= '0;
            cnt_reg     <= '0;
            ovs_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            win_i_reg   <= '0;
            win_v_reg   <= '0;
            pcnt_reg    <= '0;
            ncnt_reg    <= '0;
            pv_reg      <= '0;
            nv_reg      <= '0;
            pd_reg      <= '0;
            nd_reg      <= '0;
            pc_reg      <= '0;
            nc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                armed_reg <= armed_next;
                done_reg  <= done_next;
                phase_reg <= phase_next;
                half_reg  <= half_next;
                cnt_reg   <= cnt_next;
                ovs_reg   <= ovs_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                win_i_reg <= win_i_next;
                win_v_reg <= win_v_next;
                pcnt_reg  <= pcnt_next;
                ncnt_reg  <= ncnt_next;
                pv_reg    <= pv_next;
                nv_reg    <= nv_next;
                pd_reg    <= pd_next;
                nd_reg    <= nd_next;
                pc_reg    <= pc_next;
                nc_reg    <= nc_next;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg.status               <= status;
            result_reg.drive_command        <= drive;
            result_reg.positive_half_count  <= pcnt_next;
            result_reg.negative_half_count  <= ncnt_next;
            result_reg.positive_voltage_sum <= pv_next;
            result_reg.negative_voltage_sum <= nv_next;
            result_reg.positive_delta_sum   <= pd_next;
            result_reg.negative_delta_sum   <= nd_next;
            result_reg.positive_current_sum <= pc_next;
            result_reg.negative_current_sum <= nc_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

endmodule

FILE: rtl/square_wave_injection_accumulator_core.sv
// Top level of the square-wave injection accumulator.
// An accepted input item is registered in the input stage, and its result is registered in the result register.
// Throughput: one item per clock; while a result waits, one more item is held
// in the input register and the input then stalls until the result is taken.
// Reset (aresetn low, synchronous): sequence disarmed, all sums and counters
// cleared, configuration registers back to their defaults, both channels empty.
module square_wave_injection_accumulator_core
    import swia_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_command,
    input  logic                   s_motor_fault,
    input  logic                   s_angle_valid,
    input  logic                   s_bus_valid,
    input  logic [15:0]            s_bus_millivolt,
    input  logic                   s_pwm_saturated,
    input  logic signed [15:0]     s_current_d,
    input  logic signed [15:0]     s_current_q,
    input  logic signed [15:0]     s_speed,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [2:0]             m_drive_command,
    output logic [11:0]            m_positive_half_count,
    output logic [11:0]            m_negative_half_count,
    output logic [37:0]            m_positive_voltage_sum,
    output logic [37:0]            m_negative_voltage_sum,
    output logic signed [27:0]     m_positive_delta_sum,
    output logic signed [27:0]     m_negative_delta_sum,
    output logic signed [39:0]     m_positive_current_sum,
    output logic signed [39:0]     m_negative_current_sum
);

    cfg_t    cfg;
    sample_t s_item;
    sample_t item;
    logic    item_valid;
    logic    take;
    result_t result;

    assign s_item.command       = s_command;
    assign s_item.motor_fault   = s_motor_fault;
    assign s_item.angle_valid   = s_angle_valid;
    assign s_item.bus_valid     = s_bus_valid;
    assign s_item.bus_millivolt = s_bus_millivolt;
    assign s_item.pwm_saturated = s_pwm_saturated;
    assign s_item.current_d     = s_current_d;
    assign s_item.current_q     = s_current_q;
    assign s_item.speed         = s_speed;

    swia_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swia_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    swia_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_status               = result.status;
    assign m_drive_command        = result.drive_command;
    assign m_positive_half_count  = result.positive_half_count;
    assign m_negative_half_count  = result.negative_half_count;
    assign m_positive_voltage_sum = result.positive_voltage_sum;
    assign m_negative_voltage_sum = result.negative_voltage_sum;
    assign m_positive_delta_sum   = result.positive_delta_sum;
    assign m_negative_delta_sum   = result.negative_delta_sum;
    assign m_positive_current_sum = result.positive_current_sum;
    assign m_negative_current_sum = result.negative_current_sum;

endmodule

FILE: rtl/swia_checker.sv
// Port-level assertions for the accumulator core, bound to the top level.
module swia_checker
    import swia_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [2:0] m_drive_command
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
                              && $stable(m_drive_command))
        else $error("stalled result item changed");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DONE |-> m_drive_command == DRV_ZERO)
        else $error("batch done without zero drive");

    a_fault_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FAULT |-> m_drive_command == DRV_ABORT)
        else $error("safety fault without abort drive");

    a_idle_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_IGNORED || m_status == ST_OVERSPEED)
        |-> m_drive_command == DRV_NONE)
        else $error("drive issued on ignored or overspeed item");

endmodule

bind square_wave_injection_accumulator_core swia_checker u_swia_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_drive_command (m_drive_command)
);
